@@ rtl/mouse_position_tracker_unit_macros.svh @@
// assertion macros shared by the checker
`ifndef MOUSE_POSITION_TRACKER_UNIT_MACROS_SVH
`define MOUSE_POSITION_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define MPT_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication, masked during reset
`define MPT_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

// next-cycle implication, also checked around reset
`define MPT_ASSERT_NXT_ALWAYS(label, clk, lhs, rhs) \
    label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

@@ rtl/mpt_pkg.sv @@
// types and constants of the mouse position tracker
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 8'd3;

    localparam logic signed [15:0] MIN_X_RESET = 16'sd0;
    localparam logic signed [15:0] MAX_X_RESET = 16'sd319;
    localparam logic signed [15:0] MIN_Y_RESET = 16'sd0;
    localparam logic signed [15:0] MAX_Y_RESET = 16'sd255;

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] max_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_y;
    } cfg_t;

    typedef struct packed {
        logic [7:0] count_x;
        logic [7:0] count_y;
        logic       left_line;
        logic       right_line;
    } item_t;

    typedef struct packed {
        logic               is_button_event;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [7:0]  delta_x;
        logic signed [7:0]  delta_y;
        logic               left_pressed;
        logic               left_released;
        logic               right_pressed;
        logic               right_released;
        logic               last;
    } event_t;

    typedef struct packed {
        logic move_valid;
        logic btn_valid;
    } ev_sel_t;

endpackage

`default_nettype wire

@@ rtl/mouse_position_tracker_unit.sv @@
// Mouse position tracker: an accepted request passes the input register, then the result
// register. Throughput one tick per cycle while the receiver keeps up and a tick yields
// at most one event; a tick with both a move and a button event holds the result register
// until both leave the single-event output port; a tick with no event still frees the input register.
// Synchronous active-low reset restores the bound registers to 0/319/0/255, clears all
// tracker state and empties both registers; the first tick afterwards only captures.
`timescale 1ns / 1ps
`default_nettype none

module mouse_position_tracker_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_count_x,
    input  wire logic [7:0]                     s_count_y,
    input  wire logic                           s_left_line,
    input  wire logic                           s_right_line,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_is_button_event,
    output logic signed [15:0]                  m_pos_x,
    output logic signed [15:0]                  m_pos_y,
    output logic signed [7:0]                   m_delta_x,
    output logic signed [7:0]                   m_delta_y,
    output logic                                m_left_pressed,
    output logic                                m_left_released,
    output logic                                m_right_pressed,
    output logic                                m_right_released,
    output logic                                m_last
);

    mpt_pkg::cfg_t    cfg_reg, cfg_next;
    mpt_pkg::item_t   item_reg;
    logic             in_valid_reg, in_valid_next;
    logic             advance;
    logic             can_load;
    logic             cfg_write;
    mpt_pkg::event_t  move_ev;
    mpt_pkg::event_t  btn_ev;
    mpt_pkg::ev_sel_t sel;
    mpt_pkg::event_t  m_ev;

    assign advance = in_valid_reg & can_load;
    assign s_ready = !in_valid_reg || advance;

    assign cfg_write = cfg_we && ((cfg_index == mpt_pkg::REG_MIN_X) ||
                                  (cfg_index == mpt_pkg::REG_MAX_X) ||
                                  (cfg_index == mpt_pkg::REG_MIN_Y) ||
                                  (cfg_index == mpt_pkg::REG_MAX_Y));

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                mpt_pkg::REG_MIN_X: begin
                    cfg_next.min_x = cfg_wdata;
                end
                mpt_pkg::REG_MAX_X: begin
                    cfg_next.max_x = cfg_wdata;
                end
                mpt_pkg::REG_MIN_Y: begin
                    cfg_next.min_y = cfg_wdata;
                end
                mpt_pkg::REG_MAX_Y: begin
                    cfg_next.max_y = cfg_wdata;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_x <= mpt_pkg::MIN_X_RESET;
            cfg_reg.max_x <= mpt_pkg::MAX_X_RESET;
            cfg_reg.min_y <= mpt_pkg::MIN_Y_RESET;
            cfg_reg.max_y <= mpt_pkg::MAX_Y_RESET;
            in_valid_reg  <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.count_x    <= s_count_x;
            item_reg.count_y    <= s_count_y;
            item_reg.left_line  <= s_left_line;
            item_reg.right_line <= s_right_line;
        end
    end

    mpt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .cfg_write (cfg_write),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .move_ev   (move_ev),
        .btn_ev    (btn_ev),
        .sel       (sel)
    );

    mpt_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .sel      (sel),
        .move_ev  (move_ev),
        .btn_ev   (btn_ev),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_ev     (m_ev),
        .can_load (can_load)
    );

    assign m_is_button_event = m_ev.is_button_event;
    assign m_pos_x           = m_ev.pos_x;
    assign m_pos_y           = m_ev.pos_y;
    assign m_delta_x         = m_ev.delta_x;
    assign m_delta_y         = m_ev.delta_y;
    assign m_left_pressed    = m_ev.left_pressed;
    assign m_left_released   = m_ev.left_released;
    assign m_right_pressed   = m_ev.right_pressed;
    assign m_right_released  = m_ev.right_released;
    assign m_last            = m_ev.last;

endmodule

`default_nettype wire

@@ rtl/mpt_core.sv @@
// tracker state and per-tick event computation
`timescale 1ns / 1ps
`default_nettype none

module mpt_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire logic            cfg_write,
    input  wire mpt_pkg::item_t  item,
    input  wire mpt_pkg::cfg_t   cfg,
    output mpt_pkg::event_t      move_ev,
    output mpt_pkg::event_t      btn_ev,
    output mpt_pkg::ev_sel_t     sel
);

    logic [7:0]         ref_x_reg, ref_x_next;
    logic [7:0]         ref_y_reg, ref_y_next;
    logic signed [15:0] cur_x_reg, cur_x_next;
    logic signed [15:0] cur_y_reg, cur_y_next;
    logic [1:0]         held_reg, held_next;
    logic               primed_reg, primed_next;

    logic [1:0]         btn;
    logic [1:0]         change;
    logic [7:0]         dx;
    logic [7:0]         dy;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic               moved;

    // exact sum, low bound first then high bound
    function automatic logic signed [15:0] move_axis(
        input logic signed [15:0] pos,
        input logic [7:0]         d,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [16:0] p;
        logic signed [16:0] lo_e;
        logic signed [16:0] hi_e;
        p    = 17'({pos[15], pos}) + 17'({{9{d[7]}}, d});
        lo_e = {lo[15], lo};
        hi_e = {hi[15], hi};
        if (p < lo_e) begin
            p = lo_e;
        end
        if (p > hi_e) begin
            p = hi_e;
        end
        return p[15:0];
    endfunction

    assign btn    = {~item.right_line, ~item.left_line};
    assign dx     = item.count_x - ref_x_reg;
    assign dy     = item.count_y - ref_y_reg;
    assign change = held_reg ^ btn;
    assign moved  = (dx != 8'd0) || (dy != 8'd0);
    assign mx     = (dx != 8'd0) ? move_axis(cur_x_reg, dx, cfg.min_x, cfg.max_x) : cur_x_reg;
    assign my     = (dy != 8'd0) ? move_axis(cur_y_reg, dy, cfg.min_y, cfg.max_y) : cur_y_reg;

    always_comb begin
        ref_x_next  = ref_x_reg;
        ref_y_next  = ref_y_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        held_next   = held_reg;
        primed_next = primed_reg;
        if (advance) begin
            ref_x_next  = item.count_x;
            ref_y_next  = item.count_y;
            held_next   = btn;
            primed_next = 1'b1;
            if (primed_reg) begin
                cur_x_next = mx;
                cur_y_next = my;
            end else begin
                cur_x_next = cfg.min_x;
                cur_y_next = cfg.min_y;
            end
        end
        if (cfg_write) begin
            primed_next = 1'b0;
        end
    end

    always_comb begin
        move_ev                 = '0;
        move_ev.is_button_event = 1'b0;
        move_ev.pos_x           = mx;
        move_ev.pos_y           = my;
        move_ev.delta_x         = dx;
        move_ev.delta_y         = dy;
        move_ev.last            = (change == 2'b00);

        btn_ev                  = move_ev;
        btn_ev.is_button_event  = 1'b1;
        btn_ev.left_pressed     = change[0] & btn[0];
        btn_ev.left_released    = change[0] & ~btn[0];
        btn_ev.right_pressed    = change[1] & btn[1];
        btn_ev.right_released   = change[1] & ~btn[1];
        btn_ev.last             = 1'b1;

        sel.move_valid          = primed_reg & moved;
        sel.btn_valid           = primed_reg & (change != 2'b00);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg  <= 8'd0;
            ref_y_reg  <= 8'd0;
            cur_x_reg  <= 16'sd0;
            cur_y_reg  <= 16'sd0;
            held_reg   <= 2'b00;
            primed_reg <= 1'b0;
        end else begin
            ref_x_reg  <= ref_x_next;
            ref_y_reg  <= ref_y_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            held_reg   <= held_next;
            primed_reg <= primed_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mpt_outbuf.sv @@
// result register holding the move and button events of one tick
`timescale 1ns / 1ps
`default_nettype none

module mpt_outbuf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire mpt_pkg::ev_sel_t sel,
    input  wire mpt_pkg::event_t  move_ev,
    input  wire mpt_pkg::event_t  btn_ev,
    input  wire logic             m_ready,
    output logic                  m_valid,
    output mpt_pkg::event_t       m_ev,
    output logic                  can_load
);

    mpt_pkg::event_t a_reg;
    mpt_pkg::event_t b_reg;
    logic            a_valid_reg, a_valid_next;
    logic            b_valid_reg, b_valid_next;
    logic            pop;

    assign m_valid  = a_valid_reg | b_valid_reg;
    assign m_ev     = a_valid_reg ? a_reg : b_reg;
    assign pop      = m_valid & m_ready;
    // free now, or the last held event leaves this cycle
    assign can_load = (!a_valid_reg && !b_valid_reg) ||
                      (pop && !(a_valid_reg && b_valid_reg));

    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (load) begin
            a_valid_next = sel.move_valid;
            b_valid_next = sel.btn_valid;
        end else if (pop) begin
            if (a_valid_reg) begin
                a_valid_next = 1'b0;
            end else begin
                b_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg <= move_ev;
            b_reg <= btn_ev;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mpt_checker.sv @@
// port-level checks of the tracker and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "mouse_position_tracker_unit_macros.svh"

module mpt_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_is_button_event,
    input wire logic signed [15:0] m_pos_x,
    input wire logic signed [15:0] m_pos_y,
    input wire logic signed [7:0] m_delta_x,
    input wire logic signed [7:0] m_delta_y,
    input wire logic              m_left_pressed,
    input wire logic              m_left_released,
    input wire logic              m_right_pressed,
    input wire logic              m_right_released,
    input wire logic              m_last
);

    logic any_flag;

    assign any_flag = m_left_pressed | m_left_released | m_right_pressed | m_right_released;

    // output register empties under reset
    `MPT_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // stalled request keeps its position
    `MPT_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_is_button_event))

    // a move event always carries a delta and no button flags
    `MPT_ASSERT_IMP(a_move_shape, aclk, aresetn, m_valid && !m_is_button_event, (m_delta_x != 8'sd0 || m_delta_y != 8'sd0) && !any_flag)

    // a button event closes the tick and names a changed button
    `MPT_ASSERT_IMP(a_btn_shape, aclk, aresetn, m_valid && m_is_button_event, m_last && any_flag)

endmodule

bind mouse_position_tracker_unit mpt_checker u_mpt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_is_button_event(m_is_button_event),
    .m_pos_x          (m_pos_x),
    .m_pos_y          (m_pos_y),
    .m_delta_x        (m_delta_x),
    .m_delta_y        (m_delta_y),
    .m_left_pressed   (m_left_pressed),
    .m_left_released  (m_left_released),
    .m_right_pressed  (m_right_pressed),
    .m_right_released (m_right_released),
    .m_last           (m_last)
);

`default_nettype wire

@@ sim/mpt_event_checker.sv @@
// checker for the mouse position tracker: predicts events from requests and compares them
`timescale 1ns / 1ps

module mpt_event_checker
    import mpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_count_x,
    input  logic [7:0]            s_count_y,
    input  logic                  s_left_line,
    input  logic                  s_right_line,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_is_button_event,
    input  logic signed [15:0]    m_pos_x,
    input  logic signed [15:0]    m_pos_y,
    input  logic signed [7:0]     m_delta_x,
    input  logic signed [7:0]     m_delta_y,
    input  logic                  m_left_pressed,
    input  logic                  m_left_released,
    input  logic                  m_right_pressed,
    input  logic                  m_right_released,
    input  logic                  m_last,
    output int                    mismatches,
    output int                    events_due
);

    cfg_t               bounds;
    logic [7:0]         seen_x;
    logic [7:0]         seen_y;
    logic signed [15:0] track_x;
    logic signed [15:0] track_y;
    logic [1:0]         held_down;
    logic               armed;
    event_t             due_q[$];
    int                 err_count = 0;

    // sum is formed at full width, then low bound first and high bound second
    function automatic logic signed [15:0] step_axis(input logic signed [15:0] pos,
                                                     input logic signed [7:0] d,
                                                     input logic signed [15:0] lo,
                                                     input logic signed [15:0] hi);
        int sum;
        sum = pos + d;
        if (sum < lo) sum = lo;
        if (sum > hi) sum = hi;
        return sum[15:0];
    endfunction

    function automatic string describe(input event_t e);
        return $sformatf({"btn=%0b pos=(%0d,%0d) delta=(%0d,%0d) ",
                          "lp=%0b lr=%0b rp=%0b rr=%0b last=%0b"},
                         e.is_button_event, e.pos_x, e.pos_y, e.delta_x, e.delta_y,
                         e.left_pressed, e.left_released, e.right_pressed, e.right_released,
                         e.last);
    endfunction

    task automatic predict_tick(input logic [7:0] cx, input logic [7:0] cy,
                                input logic left_line, input logic right_line);
        logic [7:0] dx;
        logic [7:0] dy;
        logic [1:0] now_down;
        logic [1:0] toggled;
        event_t     ev;
        now_down = {~right_line, ~left_line};
        // first request after reset or a bound write only captures
        if (!armed) begin
            seen_x    = cx;
            seen_y    = cy;
            track_x   = bounds.min_x;
            track_y   = bounds.min_y;
            held_down = now_down;
            armed     = 1'b1;
            return;
        end
        dx = cx - seen_x;
        dy = cy - seen_y;
        if (dx != 8'd0) begin
            track_x = step_axis(track_x, dx, bounds.min_x, bounds.max_x);
            seen_x  = cx;
        end
        if (dy != 8'd0) begin
            track_y = step_axis(track_y, dy, bounds.min_y, bounds.max_y);
            seen_y  = cy;
        end
        toggled   = held_down ^ now_down;
        held_down = now_down;

        ev         = '0;
        ev.pos_x   = track_x;
        ev.pos_y   = track_y;
        ev.delta_x = dx;
        ev.delta_y = dy;
        if (dx != 8'd0 || dy != 8'd0) begin
            ev.last = (toggled == 2'b00);
            due_q.push_back(ev);
        end
        if (toggled != 2'b00) begin
            ev.is_button_event = 1'b1;
            ev.left_pressed    = toggled[0] & now_down[0];
            ev.left_released   = toggled[0] & ~now_down[0];
            ev.right_pressed   = toggled[1] & now_down[1];
            ev.right_released  = toggled[1] & ~now_down[1];
            ev.last            = 1'b1;
            due_q.push_back(ev);
        end
    endtask

    always @(posedge aclk) begin
        event_t got;
        event_t want;
        if (!aresetn) begin
            bounds.min_x = MIN_X_RESET;
            bounds.max_x = MAX_X_RESET;
            bounds.min_y = MIN_Y_RESET;
            bounds.max_y = MAX_Y_RESET;
            seen_x       = 8'd0;
            seen_y       = 8'd0;
            track_x      = 16'sd0;
            track_y      = 16'sd0;
            held_down    = 2'b00;
            armed        = 1'b0;
            due_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_is_button_event, m_pos_x, m_pos_y, m_delta_x, m_delta_y,
                       m_left_pressed, m_left_released, m_right_pressed, m_right_released,
                       m_last};
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected event, expected none, actual %s",
                             $time, describe(got));
                    err_count++;
                end else begin
                    want = due_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: event mismatch, expected %s, actual %s",
                                 $time, describe(want), describe(got));
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_tick(s_count_x, s_count_y, s_left_line, s_right_line);
            if (cfg_we) begin
                // an index past the register list changes nothing
                case (cfg_index)
                    REG_MIN_X: begin
                        bounds.min_x = cfg_wdata;
                        armed        = 1'b0;
                    end
                    REG_MAX_X: begin
                        bounds.max_x = cfg_wdata;
                        armed        = 1'b0;
                    end
                    REG_MIN_Y: begin
                        bounds.min_y = cfg_wdata;
                        armed        = 1'b0;
                    end
                    REG_MAX_Y: begin
                        bounds.max_y = cfg_wdata;
                        armed        = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        events_due <= due_q.size();
        mismatches <= err_count;
    end

endmodule

@@ sim/tb.sv @@
// testbench top for the mouse position tracker: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb;
    import mpt_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic [7:0]            s_count_x    = 8'd0;
    logic [7:0]            s_count_y    = 8'd0;
    logic                  s_left_line  = 1'b1;
    logic                  s_right_line = 1'b1;
    logic                  m_ready      = 1'b0;

    logic                  s_ready;
    logic                  m_valid;
    logic                  m_is_button_event;
    logic signed [15:0]    m_pos_x;
    logic signed [15:0]    m_pos_y;
    logic signed [7:0]     m_delta_x;
    logic signed [7:0]     m_delta_y;
    logic                  m_left_pressed;
    logic                  m_left_released;
    logic                  m_right_pressed;
    logic                  m_right_released;
    logic                  m_last;

    int mismatches;
    int events_due;
    int idle_cycles = 0;
    int ready_mode  = 0;
    int mode_left   = 0;

    logic [7:0] cur_cx = 8'd0;
    logic [7:0] cur_cy = 8'd0;
    logic       cur_l  = 1'b1;
    logic       cur_r  = 1'b1;

    always #6 aclk = ~aclk;

    mouse_position_tracker_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_count_x        (s_count_x),
        .s_count_y        (s_count_y),
        .s_left_line      (s_left_line),
        .s_right_line     (s_right_line),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_button_event(m_is_button_event),
        .m_pos_x          (m_pos_x),
        .m_pos_y          (m_pos_y),
        .m_delta_x        (m_delta_x),
        .m_delta_y        (m_delta_y),
        .m_left_pressed   (m_left_pressed),
        .m_left_released  (m_left_released),
        .m_right_pressed  (m_right_pressed),
        .m_right_released (m_right_released),
        .m_last           (m_last)
    );

    mpt_event_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_count_x        (s_count_x),
        .s_count_y        (s_count_y),
        .s_left_line      (s_left_line),
        .s_right_line     (s_right_line),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_button_event(m_is_button_event),
        .m_pos_x          (m_pos_x),
        .m_pos_y          (m_pos_y),
        .m_delta_x        (m_delta_x),
        .m_delta_y        (m_delta_y),
        .m_left_pressed   (m_left_pressed),
        .m_left_released  (m_left_released),
        .m_right_pressed  (m_right_pressed),
        .m_right_released (m_right_released),
        .m_last           (m_last),
        .mismatches       (mismatches),
        .events_due       (events_due)
    );

    // receiver: switches between always ready, light, heavy and long stalls
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ($urandom_range(0, 31) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // holds the request until it is taken; valid is left high for the caller
    task automatic send_tick(input logic [7:0] cx, input logic [7:0] cy,
                             input logic left_line, input logic right_line);
        s_valid      <= 1'b1;
        s_count_x    <= cx;
        s_count_y    <= cy;
        s_left_line  <= left_line;
        s_right_line <= right_line;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [7:0] next_count(input logic [7:0] c);
        case ($urandom_range(0, 9))
            0, 1, 2: return c;
            3, 4, 5, 6: return c + 8'($urandom_range(0, 16)) - 8'd8;
            7, 8: return 8'($urandom);
            default: return $urandom_range(0, 1) ? c + 8'h7f : c + 8'h80;
        endcase
    endfunction

    task automatic random_ticks(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst) begin
                cur_cx = next_count(cur_cx);
                cur_cy = next_count(cur_cy);
                if ($urandom_range(0, 4) == 0) cur_l = ~cur_l;
                if ($urandom_range(0, 4) == 0) cur_r = ~cur_r;
                send_tick(cur_cx, cur_cy, cur_l, cur_r);
            end
            left -= burst;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    // a request that yields no event may still be in flight when the queue drains
    task automatic settle();
        do @(posedge aclk); while (events_due != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic write_bounds(input logic [15:0] lo_x, input logic [15:0] hi_x,
                                input logic [15:0] lo_y, input logic [15:0] hi_y);
        settle();
        write_reg(REG_MIN_X, lo_x);
        write_reg(REG_MAX_X, hi_x);
        write_reg(REG_MIN_Y, lo_y);
        write_reg(REG_MAX_Y, hi_y);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int lo_x;
        int lo_y;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // default box: capture, extreme deltas, wraps, clamps and button combos
        send_tick(8'h10, 8'hf0, 1'b1, 1'b1);
        send_tick(8'h10, 8'hf0, 1'b1, 1'b1);
        send_tick(8'h8f, 8'hf0, 1'b1, 1'b1);
        send_tick(8'h0f, 8'hf0, 1'b1, 1'b1);
        send_tick(8'h0f, 8'h05, 1'b1, 1'b1);
        send_tick(8'h0f, 8'h05, 1'b0, 1'b1);
        send_tick(8'h8e, 8'h05, 1'b0, 1'b0);
        send_tick(8'hff, 8'hff, 1'b1, 1'b1);
        send_tick(8'hff, 8'h7e, 1'b0, 1'b0);
        send_tick(8'h7e, 8'h7e, 1'b0, 1'b0);
        send_tick(8'hfd, 8'hfd, 1'b0, 1'b0);
        send_tick(8'h00, 8'h00, 1'b1, 1'b0);
        send_tick(8'h80, 8'h80, 1'b1, 1'b1);
        send_tick(8'h80, 8'h80, 1'b1, 1'b1);
        send_tick(8'h00, 8'h00, 1'b1, 1'b1);
        send_tick(8'h80, 8'hff, 1'b0, 1'b1);
        send_tick(8'h80, 8'hff, 1'b1, 1'b0);
        s_valid <= 1'b0;
        cur_cx = 8'h80;
        cur_cy = 8'hff;
        cur_l  = 1'b1;
        cur_r  = 1'b0;

        random_ticks(150);

        // full signed range on both axes
        write_bounds(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        random_ticks(150);

        // boxes against the ends so sums leave the 16-bit range
        write_bounds(16'(32700), 16'h7fff, 16'h8000, 16'(-32700));
        random_ticks(150);

        // crossed bounds resolve to max
        write_bounds(16'(50), 16'(-50), 16'(200), 16'(10));
        random_ticks(100);

        // single-point box
        write_bounds(16'(-5), 16'(-5), 16'h7fff, 16'h7fff);
        random_ticks(80);

        // writes outside the register list leave the tracker primed
        settle();
        write_reg(CFG_IDX_W'($urandom_range(4, 254)), 16'($urandom));
        write_reg({CFG_IDX_W{1'b1}}, 16'($urandom));
        cfg_we <= 1'b0;
        random_ticks(100);

        // one register alone still recaptures
        settle();
        write_reg(REG_MAX_Y, 16'(40));
        cfg_we <= 1'b0;
        random_ticks(100);

        repeat (3) begin
            lo_x = $urandom_range(0, 400) - 200;
            lo_y = $urandom_range(0, 400) - 200;
            write_bounds(16'(lo_x), 16'(lo_x + $urandom_range(0, 300)),
                         16'(lo_y), 16'(lo_y + $urandom_range(0, 300)));
            random_ticks(120);
        end

        do @(posedge aclk); while (events_due != 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
